// ===== src/bcim_pkg.sv =====
`timescale 1ns / 1ps

package bcim_pkg;

    // cells in one scan, a power of two so the mean is a shift
    localparam int CELLS = 4;
    localparam int IDX_W = 4;
    localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(CELLS - 1);

    localparam int MV_W   = 13;
    localparam int CODE_W = 12;
    localparam int SUM_W  = 17;
    localparam int SOC_W  = 7;
    localparam int LIM_W  = 10;

    localparam logic [MV_W-1:0]  MV_SAT      = '1;
    localparam logic [SUM_W-1:0] SCAN_SIZE   = SUM_W'(CELLS);
    localparam logic [SOC_W-1:0] PERCENT_MAX = SOC_W'(100);

    // full scale is 2^CODE_W - 1: quotient is the high part plus a 0..2 correction
    localparam int CONV_W = 15;
    localparam logic [CONV_W-1:0] FULL_SCALE    = CONV_W'(4095);
    localparam logic [CONV_W-1:0] FULL_SCALE_X2 = CONV_W'(8190);

    // charge percent divider: two quotient bits per cycle
    localparam int DIV_W      = 26;
    localparam int DIV_CYCLES = DIV_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MV    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MV    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BAND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BAND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIGHT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOSE     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TREND     = 3'd7;

    // trend codes
    localparam logic [1:0] TREND_STABLE = 2'd0;
    localparam logic [1:0] TREND_UP     = 2'd1;
    localparam logic [1:0] TREND_DOWN   = 2'd2;

    typedef struct packed {
        logic cap_code;
        logic do_mul;
        logic conv;
        logic div_start;
        logic acc;
        logic mean_ld;
        logic soc_mul;
        logic out_ld;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic last_cell;
        logic out_full;
    } dp_sts_t;

    // first member lands in the top bits, so fields are listed high to low
    typedef struct packed {
        logic [1:0]       trend;
        logic             warning;
        logic [LIM_W-1:0] limit_mv;
        logic [SOC_W-1:0] charge_percent;
        logic [MV_W-1:0]  mean_mv;
        logic [MV_W-1:0]  spread_mv;
        logic [IDX_W-1:0] weakest_index;
        logic [IDX_W-1:0] strongest_index;
        logic [MV_W-1:0]  lowest_mv;
        logic [MV_W-1:0]  highest_mv;
    } result_t;

endpackage

// ===== src/bcim_div.sv =====
`timescale 1ns / 1ps

module bcim_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bcim_pkg::DIV_W-1:0]   dividend,
    input  logic [bcim_pkg::MV_W-1:0]    divisor,
    output logic                         done,
    output logic [bcim_pkg::DIV_W-1:0]   quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [bcim_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [bcim_pkg::MV_W-1:0]         den_reg, den_next;
    logic [bcim_pkg::MV_W-1:0]         rem_reg, rem_next;
    logic [bcim_pkg::DIV_W-1:0]        num_reg, num_next;
    logic [bcim_pkg::MV_W:0]           trial1, trial2;
    logic [bcim_pkg::MV_W-1:0]         rem1;
    logic                              bit1, bit2;

    // restoring division, two bits per cycle, quotient shifts into num_reg
    always_comb
    begin
        trial1 = {rem_reg, num_reg[bcim_pkg::DIV_W-1]};
        bit1   = (trial1 >= {1'b0, den_reg});
        rem1   = bit1 ? bcim_pkg::MV_W'(trial1 - {1'b0, den_reg})
                      : trial1[bcim_pkg::MV_W-1:0];
        trial2 = {rem1, num_reg[bcim_pkg::DIV_W-2]};
        bit2   = (trial2 >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            den_next  = divisor;
            rem_next  = '0;
            num_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = bit2 ? bcim_pkg::MV_W'(trial2 - {1'b0, den_reg})
                            : trial2[bcim_pkg::MV_W-1:0];
            num_next = {num_reg[bcim_pkg::DIV_W-3:0], bit1, bit2};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == bcim_pkg::DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        num_reg <= num_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

// ===== src/bcim_ctrl.sv =====
`timescale 1ns / 1ps

module bcim_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  bcim_pkg::dp_sts_t sts,
    output bcim_pkg::dp_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MUL    = 4'd1;
    localparam logic [3:0] ST_CONV   = 4'd2;
    localparam logic [3:0] ST_ACC    = 4'd3;
    localparam logic [3:0] ST_MEAN   = 4'd4;
    localparam logic [3:0] ST_SMUL   = 4'd5;
    localparam logic [3:0] ST_SSTART = 4'd6;
    localparam logic [3:0] ST_SWAIT  = 4'd7;
    localparam logic [3:0] ST_FIN    = 4'd8;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.cap_code = 1'b1;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.do_mul = 1'b1;
                state_next = ST_CONV;
            end
            ST_CONV:
            begin
                cmd.conv   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = sts.last_cell ? ST_MEAN : ST_IDLE;
            end
            ST_MEAN:
            begin
                cmd.mean_ld = 1'b1;
                state_next  = ST_SMUL;
            end
            ST_SMUL:
            begin
                cmd.soc_mul = 1'b1;
                state_next  = ST_SSTART;
            end
            ST_SSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_SWAIT;
            end
            ST_SWAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!sts.out_full)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_ld |-> !sts.out_full)
        else $error("result loaded while output register still full");

    a_done_not_immediate: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !sts.div_done)
        else $error("divider done one cycle after start");

    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC && sts.last_cell) |=> state_reg == ST_MEAN)
        else $error("last cell did not move on to the mean");

    a_acc_after_conv: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc |-> $past(cmd.conv))
        else $error("cell accumulated without a finished conversion");

endmodule

// ===== src/bcim_dp.sv =====
`timescale 1ns / 1ps

module bcim_dp
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [bcim_pkg::CODE_W-1:0]        adc_code,
    input  logic                               cfg_valid,
    input  logic [bcim_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bcim_pkg::MV_W-1:0]          cfg_data,
    input  logic                               out_taken,
    input  bcim_pkg::dp_cmd_t                  cmd,
    output bcim_pkg::dp_sts_t                  sts,
    output logic                               out_valid,
    output bcim_pkg::result_t                  result
);

    // configuration
    logic [bcim_pkg::MV_W-1:0]  min_mv_reg, max_mv_reg;
    logic [bcim_pkg::SOC_W-1:0] high_band_reg, low_band_reg;
    logic [bcim_pkg::LIM_W-1:0] tight_reg, middle_reg, loose_reg, trend_band_reg;

    // scan state
    logic [bcim_pkg::IDX_W-1:0] cells_seen_reg;
    logic [bcim_pkg::SUM_W-1:0] sum_reg;
    logic [bcim_pkg::MV_W-1:0]  high_mv_reg, low_mv_reg;
    logic [bcim_pkg::IDX_W-1:0] high_idx_reg, low_idx_reg;
    logic [bcim_pkg::MV_W-1:0]  prev_spread_reg;
    logic                       out_valid_reg;
    bcim_pkg::result_t          result_reg;

    // payload
    logic [bcim_pkg::CODE_W-1:0] code_reg;
    logic [bcim_pkg::DIV_W-1:0]  prod_reg;
    logic [bcim_pkg::MV_W-1:0]   mv_reg;
    logic [bcim_pkg::MV_W-1:0]   mean_reg;

    logic [bcim_pkg::MV_W-1:0]   span;
    logic                        div_done;
    logic [bcim_pkg::DIV_W-1:0]  quotient;
    logic [bcim_pkg::DIV_W-bcim_pkg::CODE_W-1:0] conv_high;
    logic [bcim_pkg::CONV_W-1:0] conv_rem;
    logic [1:0]                  conv_step;
    logic [bcim_pkg::MV_W-1:0]   conv_q;
    logic [bcim_pkg::MV_W:0]     mv_wide;
    logic [bcim_pkg::MV_W-1:0]   mv;
    logic [bcim_pkg::MV_W-1:0]   spread;
    logic [bcim_pkg::SOC_W-1:0]  soc;
    logic [bcim_pkg::LIM_W-1:0]  limit;
    logic [bcim_pkg::MV_W:0]     prev_plus_band, spread_plus_band;
    logic [1:0]                  trend;
    logic [bcim_pkg::MV_W-1:0]   mean_over_min;

    assign span = (max_mv_reg > min_mv_reg) ? (max_mv_reg - min_mv_reg) : '0;

    // divider only forms the charge percent
    bcim_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (span),
        .done     (div_done),
        .quotient (quotient)
    );

    // product / 4095: x = hi*4096 + lo = hi*4095 + (hi + lo), and hi + lo < 3*4095
    always_comb
    begin
        conv_high = prod_reg[bcim_pkg::DIV_W-1:bcim_pkg::CODE_W];
        conv_rem  = bcim_pkg::CONV_W'(prod_reg[bcim_pkg::CODE_W-1:0])
                  + bcim_pkg::CONV_W'(conv_high);
        priority if (conv_rem >= bcim_pkg::FULL_SCALE_X2)
        begin
            conv_step = 2'd2;
        end
        else if (conv_rem >= bcim_pkg::FULL_SCALE)
        begin
            conv_step = 2'd1;
        end
        else
        begin
            conv_step = 2'd0;
        end
        // quotient never exceeds span
        conv_q = bcim_pkg::MV_W'(conv_high) + bcim_pkg::MV_W'(conv_step);
    end

    // converted cell voltage
    assign mv_wide = {1'b0, min_mv_reg} + {1'b0, conv_q};
    assign mv      = mv_wide[bcim_pkg::MV_W] ? bcim_pkg::MV_SAT : mv_wide[bcim_pkg::MV_W-1:0];

    assign mean_over_min = (mean_reg > min_mv_reg) ? (mean_reg - min_mv_reg) : '0;

    // scan-end result
    always_comb
    begin
        spread = high_mv_reg - low_mv_reg;
        if (span == '0 || mean_reg <= min_mv_reg)
        begin
            soc = '0;
        end
        else if (quotient > bcim_pkg::DIV_W'(bcim_pkg::PERCENT_MAX))
        begin
            soc = bcim_pkg::PERCENT_MAX;
        end
        else
        begin
            soc = quotient[bcim_pkg::SOC_W-1:0];
        end

        priority if (soc >= high_band_reg)
        begin
            limit = tight_reg;
        end
        else if (soc >= low_band_reg)
        begin
            limit = middle_reg;
        end
        else
        begin
            limit = loose_reg;
        end

        prev_plus_band   = {1'b0, prev_spread_reg} + (bcim_pkg::MV_W + 1)'(trend_band_reg);
        spread_plus_band = {1'b0, spread} + (bcim_pkg::MV_W + 1)'(trend_band_reg);
        priority if ({1'b0, spread} > prev_plus_band)
        begin
            trend = bcim_pkg::TREND_UP;
        end
        else if (spread_plus_band < {1'b0, prev_spread_reg})
        begin
            trend = bcim_pkg::TREND_DOWN;
        end
        else
        begin
            trend = bcim_pkg::TREND_STABLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_mv_reg     <= bcim_pkg::MV_W'(3000);
            max_mv_reg     <= bcim_pkg::MV_W'(4200);
            high_band_reg  <= bcim_pkg::SOC_W'(80);
            low_band_reg   <= bcim_pkg::SOC_W'(30);
            tight_reg      <= bcim_pkg::LIM_W'(50);
            middle_reg     <= bcim_pkg::LIM_W'(100);
            loose_reg      <= bcim_pkg::LIM_W'(150);
            trend_band_reg <= bcim_pkg::LIM_W'(10);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bcim_pkg::CFG_MIN_MV:    min_mv_reg     <= cfg_data;
                bcim_pkg::CFG_MAX_MV:    max_mv_reg     <= cfg_data;
                bcim_pkg::CFG_HIGH_BAND: high_band_reg  <= cfg_data[bcim_pkg::SOC_W-1:0];
                bcim_pkg::CFG_LOW_BAND:  low_band_reg   <= cfg_data[bcim_pkg::SOC_W-1:0];
                bcim_pkg::CFG_TIGHT:     tight_reg      <= cfg_data[bcim_pkg::LIM_W-1:0];
                bcim_pkg::CFG_MIDDLE:    middle_reg     <= cfg_data[bcim_pkg::LIM_W-1:0];
                bcim_pkg::CFG_LOOSE:     loose_reg      <= cfg_data[bcim_pkg::LIM_W-1:0];
                bcim_pkg::CFG_TREND:     trend_band_reg <= cfg_data[bcim_pkg::LIM_W-1:0];
                default:                 min_mv_reg     <= min_mv_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_seen_reg  <= '0;
            sum_reg         <= '0;
            high_mv_reg     <= '0;
            low_mv_reg      <= '0;
            high_idx_reg    <= '0;
            low_idx_reg     <= '0;
            prev_spread_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.acc)
            begin
                sum_reg <= sum_reg + bcim_pkg::SUM_W'(mv_reg);
                if (cells_seen_reg == '0)
                begin
                    high_mv_reg  <= mv_reg;
                    low_mv_reg   <= mv_reg;
                    high_idx_reg <= '0;
                    low_idx_reg  <= '0;
                end
                else
                begin
                    if (mv_reg > high_mv_reg)
                    begin
                        high_mv_reg  <= mv_reg;
                        high_idx_reg <= cells_seen_reg;
                    end
                    if (mv_reg < low_mv_reg)
                    begin
                        low_mv_reg  <= mv_reg;
                        low_idx_reg <= cells_seen_reg;
                    end
                end
                cells_seen_reg <= (cells_seen_reg == bcim_pkg::LAST_CELL)
                                  ? '0 : cells_seen_reg + 1'b1;
            end
            if (cmd.out_ld)
            begin
                prev_spread_reg <= spread;
                sum_reg         <= '0;
                out_valid_reg   <= 1'b1;
            end
            else if (out_taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_code)
        begin
            code_reg <= adc_code;
        end
        if (cmd.do_mul)
        begin
            prod_reg <= bcim_pkg::DIV_W'(code_reg) * bcim_pkg::DIV_W'(span);
        end
        else if (cmd.soc_mul)
        begin
            prod_reg <= bcim_pkg::DIV_W'(mean_over_min)
                      * bcim_pkg::DIV_W'(bcim_pkg::PERCENT_MAX);
        end
        if (cmd.conv)
        begin
            mv_reg <= mv;
        end
        if (cmd.mean_ld)
        begin
            mean_reg <= bcim_pkg::MV_W'(sum_reg / bcim_pkg::SCAN_SIZE);
        end
        if (cmd.out_ld)
        begin
            result_reg.highest_mv      <= high_mv_reg;
            result_reg.lowest_mv       <= low_mv_reg;
            result_reg.strongest_index <= high_idx_reg;
            result_reg.weakest_index   <= low_idx_reg;
            result_reg.spread_mv       <= spread;
            result_reg.mean_mv         <= mean_reg;
            result_reg.charge_percent  <= soc;
            result_reg.limit_mv        <= limit;
            result_reg.warning         <= (spread > bcim_pkg::MV_W'(limit));
            result_reg.trend           <= trend;
        end
    end

    assign sts.div_done  = div_done;
    assign sts.last_cell = (cells_seen_reg == bcim_pkg::LAST_CELL);
    assign sts.out_full  = out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign result        = result_reg;

endmodule

// ===== src/battery_cell_imbalance_monitor_unit.sv =====
`timescale 1ns / 1ps

// battery cell imbalance monitor
// s_* channel: one item per cell, 12-bit converter code, cells in scan order
// m_* channel: one item per completed scan with extremes, their cell indices,
//   spread, mean, charge percent, chosen spread limit, warning and trend
// cfg_* channel: register writes, index 0..7 as listed in bcim_pkg, always
//   ready; write only while the monitor is idle
// code to millivolts divides by 4095 with a shift, an add and a small
//   correction; the mean is a shift; one iterative divider (two quotient
//   bits per cycle, 13 steps) forms the charge percent
// a cell steps through capture, multiply, convert and accumulate before the
//   next cell is accepted
// the last cell adds mean, charge multiply, divider start, divider wait and
//   the output load, after which the result item is valid
// the result sits in an output register; while it waits the next scan's
//   cells are taken, and only the following result stalls on the receiver
//   with s_tready held low
// reset restores the register defaults, clears the scan, the previous
//   spread and the output valid flag

module battery_cell_imbalance_monitor_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata: adc_code [11:0], zero fill [15:12]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,
    // m_tdata: highest_mv, lowest_mv, strongest_index, weakest_index,
    //   spread_mv, mean_mv, charge_percent, limit_mv, warning, trend
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [79:0]                         m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bcim_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bcim_pkg::MV_W-1:0]           cfg_data
);

    bcim_pkg::dp_cmd_t cmd;
    bcim_pkg::dp_sts_t sts;
    bcim_pkg::result_t result;

    // register writes never stall
    assign cfg_ready = 1'b1;

    bcim_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bcim_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adc_code  (s_tdata[bcim_pkg::CODE_W-1:0]),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_taken (m_tvalid & m_tready),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .result    (result)
    );

    assign m_tdata = result;

endmodule
